[rtl/hdcr_pkg.sv]
package hdcr_pkg;

    // Header layout: byte index of each captured field
    localparam int unsigned HEADER_BYTES = 23;
    localparam int unsigned STEP_W = 5;

    localparam logic [STEP_W-1:0] HDR_VERSION     = STEP_W'(0);
    localparam logic [STEP_W-1:0] HDR_PROFILE     = STEP_W'(1);
    localparam logic [STEP_W-1:0] HDR_COMPAT_LAST = STEP_W'(5);
    localparam logic [STEP_W-1:0] HDR_CONSTR_LAST = STEP_W'(11);
    localparam logic [STEP_W-1:0] HDR_LEVEL       = STEP_W'(12);
    localparam logic [STEP_W-1:0] HDR_LSM1        = STEP_W'(21);
    localparam logic [STEP_W-1:0] HDR_LAST        = STEP_W'(HEADER_BYTES - 1);

    // Only a first byte of this value starts a valid record
    localparam logic [7:0] CONFIG_VERSION = 8'd1;

    // Body bytes that carry the NAL unit header
    localparam logic [STEP_W-1:0] NAL_HEAD_BYTES = STEP_W'(2);

    // Total payload width of one result, padded to whole bytes
    localparam int unsigned RES_DATA_BITS = 129;
    localparam int unsigned RES_TDATA_W = ((RES_DATA_BITS + 7) / 8) * 8;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_ARRAY  = 3'd1,
        PH_ULEN   = 3'd2,
        PH_UBODY  = 3'd3,
        PH_DONE   = 3'd4,
        PH_ERROR  = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        KIND_HEADER     = 3'd0,
        KIND_HEADER_FIN = 3'd1,
        KIND_NAL        = 3'd2,
        KIND_NAL_FIN    = 3'd3,
        KIND_FIN        = 3'd4,
        KIND_ERROR      = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t        record_kind;
        logic [1:0]   profile_space;
        logic         tier_flag;
        logic [4:0]   profile_idc;
        logic [31:0]  compat_flags;
        logic [47:0]  constraint_flags;
        logic [7:0]   level_idc;
        logic [1:0]   length_size_minus_one;
        logic [5:0]   nal_type;
        logic [5:0]   nal_layer;
        logic [2:0]   nal_temporal_plus1;
        logic [15:0]  nal_bytes;
    } result_t;

endpackage

[rtl/hdcr_core.sv]
module hdcr_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        byte_in,
    input  logic              last_in,
    output logic              emit,
    output hdcr_pkg::result_t res
);

    hdcr_pkg::phase_t                 phase_reg, phase_next;
    logic [hdcr_pkg::STEP_W-1:0]      step_count_reg, step_count_next;
    logic [7:0]                       arrays_left_reg, arrays_left_next;
    logic [15:0]                      units_left_reg, units_left_next;
    logic [15:0]                      unit_bytes_left_reg, unit_bytes_left_next;
    logic [15:0]                      unit_head_reg, unit_head_next;
    logic [15:0]                      unit_length_reg, unit_length_next;
    logic [31:0]                      held_compat_reg, held_compat_next;
    logic [47:0]                      held_constraint_reg, held_constraint_next;
    logic [17:0]                      held_pl_reg, held_pl_next;

    logic do_adv;
    logic adv_done;
    logic res_hdr;
    logic res_arr;
    logic res_nal;
    logic res_err;

    // Parse one byte: next state and the result it causes
    always_comb
    begin
        phase_next           = phase_reg;
        step_count_next      = step_count_reg;
        arrays_left_next     = arrays_left_reg;
        units_left_next      = units_left_reg;
        unit_bytes_left_next = unit_bytes_left_reg;
        unit_head_next       = unit_head_reg;
        unit_length_next     = unit_length_reg;
        held_compat_next     = held_compat_reg;
        held_constraint_next = held_constraint_reg;
        held_pl_next         = held_pl_reg;
        do_adv   = 1'b0;
        adv_done = 1'b0;
        res_hdr  = 1'b0;
        res_arr  = 1'b0;
        res_nal  = 1'b0;
        res_err  = 1'b0;

        unique case (phase_reg)
            hdcr_pkg::PH_HEADER:
            begin
                step_count_next = step_count_reg + 1'b1;
                if (step_count_reg == hdcr_pkg::HDR_VERSION)
                begin
                    if (byte_in != hdcr_pkg::CONFIG_VERSION)
                    begin
                        phase_next      = hdcr_pkg::PH_ERROR;
                        step_count_next = step_count_reg;
                        res_err         = 1'b1;
                    end
                end
                else if (step_count_reg == hdcr_pkg::HDR_PROFILE)
                begin
                    held_pl_next = {byte_in, held_pl_reg[9:0]};
                end
                else if (step_count_reg <= hdcr_pkg::HDR_COMPAT_LAST)
                begin
                    held_compat_next = {held_compat_reg[23:0], byte_in};
                end
                else if (step_count_reg <= hdcr_pkg::HDR_CONSTR_LAST)
                begin
                    held_constraint_next = {held_constraint_reg[39:0], byte_in};
                end
                else if (step_count_reg == hdcr_pkg::HDR_LEVEL)
                begin
                    held_pl_next = {held_pl_reg[17:10], byte_in, held_pl_reg[1:0]};
                end
                else if (step_count_reg == hdcr_pkg::HDR_LSM1)
                begin
                    held_pl_next = {held_pl_reg[17:2], byte_in[1:0]};
                end
                else if (step_count_reg == hdcr_pkg::HDR_LAST)
                begin
                    arrays_left_next = byte_in;
                    units_left_next  = 16'd0;
                    do_adv           = 1'b1;
                    res_hdr          = 1'b1;
                end
            end
            hdcr_pkg::PH_ARRAY:
            begin
                if (step_count_reg == hdcr_pkg::STEP_W'(0))
                begin
                    step_count_next = hdcr_pkg::STEP_W'(1);
                end
                else if (step_count_reg == hdcr_pkg::STEP_W'(1))
                begin
                    units_left_next = {byte_in, 8'd0};
                    step_count_next = hdcr_pkg::STEP_W'(2);
                end
                else
                begin
                    units_left_next = {units_left_reg[15:8], byte_in};
                    do_adv          = 1'b1;
                    res_arr         = 1'b1;
                end
            end
            hdcr_pkg::PH_ULEN:
            begin
                if (step_count_reg == hdcr_pkg::STEP_W'(0))
                begin
                    unit_length_next = {byte_in, 8'd0};
                    step_count_next  = hdcr_pkg::STEP_W'(1);
                end
                else
                begin
                    unit_length_next     = {unit_length_reg[15:8], byte_in};
                    unit_bytes_left_next = {unit_length_reg[15:8], byte_in};
                    unit_head_next       = 16'd0;
                    step_count_next      = hdcr_pkg::STEP_W'(0);
                    if ({unit_length_reg[15:8], byte_in} == 16'd0)
                    begin
                        do_adv  = 1'b1;
                        res_nal = 1'b1;
                    end
                    else
                    begin
                        phase_next = hdcr_pkg::PH_UBODY;
                    end
                end
            end
            hdcr_pkg::PH_UBODY:
            begin
                if (step_count_reg < hdcr_pkg::NAL_HEAD_BYTES)
                begin
                    if (step_count_reg == hdcr_pkg::STEP_W'(0))
                        unit_head_next = {byte_in, unit_head_reg[7:0]};
                    else
                        unit_head_next = {unit_head_reg[15:8], unit_head_reg[7:0] | byte_in};
                    step_count_next = step_count_reg + 1'b1;
                end
                unit_bytes_left_next = unit_bytes_left_reg - 16'd1;
                if (unit_bytes_left_next == 16'd0)
                begin
                    do_adv  = 1'b1;
                    res_nal = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // Advance to the next unit, the next array, or the end
        if (do_adv)
        begin
            step_count_next = hdcr_pkg::STEP_W'(0);
            if (units_left_next != 16'd0)
            begin
                units_left_next = units_left_next - 16'd1;
                phase_next      = hdcr_pkg::PH_ULEN;
            end
            else if (arrays_left_next != 8'd0)
            begin
                arrays_left_next = arrays_left_next - 8'd1;
                phase_next       = hdcr_pkg::PH_ARRAY;
            end
            else
            begin
                phase_next = hdcr_pkg::PH_DONE;
                adv_done   = 1'b1;
            end
        end

        // Build the result from the updated state
        res = '0;
        res.profile_space         = held_pl_next[17:16];
        res.tier_flag             = held_pl_next[15];
        res.profile_idc           = held_pl_next[14:10];
        res.compat_flags          = held_compat_next;
        res.constraint_flags      = held_constraint_next;
        res.level_idc             = held_pl_next[9:2];
        res.length_size_minus_one = held_pl_next[1:0];
        if (res_nal)
        begin
            res.nal_type           = unit_head_next[14:9];
            res.nal_layer          = unit_head_next[8:3];
            res.nal_temporal_plus1 = unit_head_next[2:0];
            res.nal_bytes          = unit_length_next;
            res.record_kind        = adv_done ? hdcr_pkg::KIND_NAL_FIN
                                              : hdcr_pkg::KIND_NAL;
        end
        else if (res_arr)
        begin
            res.record_kind = hdcr_pkg::KIND_FIN;
        end
        else
        begin
            res.record_kind = adv_done ? hdcr_pkg::KIND_HEADER_FIN
                                       : hdcr_pkg::KIND_HEADER;
        end
        emit = res_hdr || res_nal || (res_arr && adv_done);

        // Early end: record cut off before it finished
        if (last_in && (phase_next == hdcr_pkg::PH_HEADER || phase_next == hdcr_pkg::PH_ARRAY ||
                        phase_next == hdcr_pkg::PH_ULEN || phase_next == hdcr_pkg::PH_UBODY))
        begin
            res_err = 1'b1;
        end
        if (res_err)
        begin
            res             = '0;
            res.record_kind = hdcr_pkg::KIND_ERROR;
            emit            = 1'b1;
        end

        // Restart after the last byte of a record
        if (last_in)
        begin
            phase_next           = hdcr_pkg::PH_HEADER;
            step_count_next      = '0;
            arrays_left_next     = '0;
            units_left_next      = '0;
            unit_bytes_left_next = '0;
            unit_head_next       = '0;
            unit_length_next     = '0;
            held_compat_next     = '0;
            held_constraint_next = '0;
            held_pl_next         = '0;
        end
    end

    // Hold parser state; advance only on an accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= hdcr_pkg::PH_HEADER;
            step_count_reg      <= '0;
            arrays_left_reg     <= '0;
            units_left_reg      <= '0;
            unit_bytes_left_reg <= '0;
            unit_head_reg       <= '0;
            unit_length_reg     <= '0;
            held_compat_reg     <= '0;
            held_constraint_reg <= '0;
            held_pl_reg         <= '0;
        end
        else if (step)
        begin
            phase_reg           <= phase_next;
            step_count_reg      <= step_count_next;
            arrays_left_reg     <= arrays_left_next;
            units_left_reg      <= units_left_next;
            unit_bytes_left_reg <= unit_bytes_left_next;
            unit_head_reg       <= unit_head_next;
            unit_length_reg     <= unit_length_next;
            held_compat_reg     <= held_compat_next;
            held_constraint_reg <= held_constraint_next;
            held_pl_reg         <= held_pl_next;
        end
    end

    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (step && last_in) |=> (phase_reg == hdcr_pkg::PH_HEADER &&
                               step_count_reg == hdcr_pkg::STEP_W'(0)))
        else $error("parser did not restart after the last byte");

    a_quiet_when_over: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == hdcr_pkg::PH_DONE || phase_reg == hdcr_pkg::PH_ERROR) |-> !emit)
        else $error("result raised after record finished or failed");

    a_body_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == hdcr_pkg::PH_UBODY) |-> (step_count_reg <= hdcr_pkg::NAL_HEAD_BYTES))
        else $error("unit body byte count passed the NAL header size");

    a_header_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == hdcr_pkg::PH_HEADER) |-> (step_count_reg <= hdcr_pkg::HDR_LAST))
        else $error("header byte index past the header");

endmodule

[rtl/hevc_decoder_config_record_parser.sv]
// HEVC decoder configuration record parser. Feed the record one byte per
// request on the slave side, with tlast on its final byte; the parser then
// restarts for the next record. It reports the header once all 23 header
// bytes are in, one NAL request per unit when its last byte arrives (its
// two header bytes and its length), a finished request when the arrays end
// on an array head, and an error for a bad version byte or a record cut
// short. Bytes after the record is finished give nothing. The block takes
// one byte every cycle unless output backpressure stalls it; a byte's
// result passes through an input register, one parse stage and a result
// register. Output backpressure stalls input only once both registers hold.
module hevc_decoder_config_record_parser (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,  // data_byte[7:0]
    input  logic                               s_tlast,  // final_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // profile_space[1:0], tier_flag[2], profile_idc[7:3], compat_flags[39:8],
    // constraint_flags[87:40], level_idc[95:88], length_size_minus_one[97:96],
    // nal_type[103:98], nal_layer[109:104], nal_temporal_plus1[112:110],
    // nal_bytes[128:113], zero fill above
    output logic [hdcr_pkg::RES_TDATA_W-1:0]   m_tdata,
    output logic [2:0]                         m_tuser   // record_kind[2:0]
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_last_reg;
    logic              out_valid_reg, out_valid_next;
    hdcr_pkg::result_t out_res_reg;

    logic              step;
    logic              emit;
    hdcr_pkg::result_t res;

    // Parse a held byte when the result register is free or draining
    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    // Hold the accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    hdcr_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .byte_in (in_byte_reg),
        .last_in (in_last_reg),
        .emit    (emit),
        .res     (res)
    );

    // Result register: load on a step, drop once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = emit;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
            out_res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.record_kind;
    assign m_tdata  = {
        (hdcr_pkg::RES_TDATA_W - hdcr_pkg::RES_DATA_BITS)'(0),
        out_res_reg.nal_bytes,
        out_res_reg.nal_temporal_plus1,
        out_res_reg.nal_layer,
        out_res_reg.nal_type,
        out_res_reg.length_size_minus_one,
        out_res_reg.level_idc,
        out_res_reg.constraint_flags,
        out_res_reg.compat_flags,
        out_res_reg.profile_idc,
        out_res_reg.tier_flag,
        out_res_reg.profile_space
    };

    a_held_byte_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !step) |=> (in_valid_reg && $stable(in_byte_reg) &&
                                     $stable(in_last_reg)))
        else $error("held byte changed before it was parsed");

    a_stall_keeps_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !step)
        else $error("parse step taken over an untaken result");

endmodule
